[design/lrud_pkg.sv]
// ----------------------------------------------------------------------------
// lrud_pkg: shared types and constants for the log ring drainer
// Command codes, result kinds, character codes and the queue item type used
// by the front and back parts of the block.
// ----------------------------------------------------------------------------
package lrud_pkg;

  // Default sizes, handed to the top level parameters
  localparam int RING_DEPTH_DEF = 4096;
  localparam int MAX_BURST_DEF  = 16;

  // Entries in the command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  localparam int CNT_W   = 32;
  localparam int CFG_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int OUT_W   = BYTE_W + 2 * CNT_W;

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  // Input command codes
  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_e;

  // Result kinds
  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_NOTICE = 1'b1
  } kind_e;

  // One queued command
  typedef struct packed {
    cmd_e              cmd;
    logic [BYTE_W-1:0] data;
  } cmd_item_t;

  // Head of the command queue as seen by the back part
  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } cmd_head_t;

endpackage

[design/lrud_front.sv]
// ----------------------------------------------------------------------------
// lrud_front: input side of the log ring drainer
// Accepts append and drain items, classifies them and holds them in a short
// queue so the input keeps flowing while the back part works on a drain.
// ----------------------------------------------------------------------------
module lrud_front import lrud_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,   // [7:0] log_byte
  input  logic              s_tuser,   // [0] command
  output cmd_head_t         head,
  input  logic              pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_item_t       queue [QUEUE_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;
  logic            push;
  logic            pop_ok;
  cmd_item_t       in_item;

  // Classify the incoming item
  always_comb begin
    in_item.cmd  = cmd_e'(s_tuser);
    in_item.data = s_tdata;
  end

  assign s_tready = (count != (PW+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign pop_ok   = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = queue[rptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= in_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop_ok) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/lrud_back.sv]
// ----------------------------------------------------------------------------
// lrud_back: ring storage and drain sequencer of the log ring drainer
// Writes appended bytes into the ring, checks for reader overrun on a drain,
// and emits the notice and ring bytes (LF expanded to CR LF) into the output
// register.
// ----------------------------------------------------------------------------
module lrud_back import lrud_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_head_t         head,
  output logic              pop,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [7:0] out_byte, [39:8] gap_bytes,
                                       // [71:40] total_lost
  output logic              m_tuser,   // [0] kind
  output logic              m_tlast    // last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   fifo_depth;
  logic [BYTE_W-1:0]  ring [RING_DEPTH];
  logic [BYTE_W-1:0]  rd_data;
  logic               mem_we;

  logic [CNT_W-1:0]   written_count;
  logic [CNT_W-1:0]   read_position;
  logic               line_feed_owed;
  logic [CNT_W-1:0]   lost_total;
  logic               notice_pending;
  logic [CNT_W-1:0]   notice_gap;
  logic [CNT_W-1:0]   behind;
  logic [BW-1:0]      room;

  // Overrun arithmetic
  logic               overrun;
  logic [CNT_W-1:0]   gap;
  logic [CNT_W:0]     lost_sum;

  // Emit decision
  logic [BW-1:0]      room_init;
  logic [BW-1:0]      room_left;
  logic               out_free;
  logic               has_result;
  logic               more;
  logic               emit_fire;
  logic               clear_notice;
  kind_e              res_kind;
  logic [BYTE_W-1:0]  res_byte;
  logic [CNT_W-1:0]   res_gap;
  logic [CNT_W-1:0]   res_total;
  logic [CNT_W-1:0]   read_position_next;
  logic               line_feed_owed_next;

  assign pop    = (state == ST_IDLE) && head.valid;
  assign mem_we = pop && (head.item.cmd == CMD_APPEND);

  // Ring memory, registered read at the reader slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[written_count[AW-1:0]] <= head.item.data;
    end
    rd_data <= ring[read_position[AW-1:0]];
  end

  // Burst size: zero acts as one, large values clip to the burst limit
  always_comb begin
    if (fifo_depth == '0) begin
      room_init = BW'(1);
    end else if (32'(fifo_depth) > 32'(MAX_BURST)) begin
      room_init = BW'(MAX_BURST);
    end else begin
      room_init = BW'(fifo_depth);
    end
  end

  // Overrun: reader is more than a ring length behind
  assign overrun  = behind > CNT_W'(RING_DEPTH);
  assign gap      = behind - CNT_W'(RING_DEPTH);
  assign lost_sum = {1'b0, lost_total} + {1'b0, gap};

  // Pick the next result: notice, owed LF, then ring byte
  always_comb begin
    res_kind            = KIND_BYTE;
    res_byte            = '0;
    res_gap             = '0;
    res_total           = '0;
    has_result          = 1'b1;
    clear_notice        = 1'b0;
    read_position_next  = read_position;
    line_feed_owed_next = line_feed_owed;
    if (notice_pending) begin
      res_kind     = KIND_NOTICE;
      res_gap      = notice_gap;
      res_total    = lost_total;
      clear_notice = 1'b1;
    end else if (line_feed_owed) begin
      res_byte            = CHAR_LF;
      line_feed_owed_next = 1'b0;
      read_position_next  = read_position + 1'b1;
    end else if (written_count != read_position) begin
      if (rd_data == CHAR_LF) begin
        res_byte            = CHAR_CR;
        line_feed_owed_next = 1'b1;
      end else begin
        res_byte           = rd_data;
        read_position_next = read_position + 1'b1;
      end
    end else begin
      has_result = 1'b0;
    end
  end

  assign room_left = room - 1'b1;
  assign more      = (room_left != '0) &&
                     (line_feed_owed_next || (written_count != read_position_next));
  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (state == ST_EMIT) && out_free && has_result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_depth <= CFG_W'(1);
    end else if (cfg_we) begin
      fifo_depth <= cfg_data;
    end
  end

  // Sequencer and drain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      written_count  <= '0;
      read_position  <= '0;
      line_feed_owed <= 1'b0;
      lost_total     <= '0;
      notice_pending <= 1'b0;
      notice_gap     <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // Output taken and no new result loaded this cycle
      if (m_tvalid && m_tready && !emit_fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.item.cmd == CMD_APPEND) begin
              written_count <= written_count + 1'b1;
            end else begin
              room  <= room_init;
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          behind <= written_count - read_position;
          state  <= ST_APPLY;
        end
        ST_APPLY: begin
          if (overrun) begin
            lost_total     <= lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];
            read_position  <= read_position + gap;
            line_feed_owed <= 1'b0;
            if (!notice_pending) begin
              notice_pending <= 1'b1;
              notice_gap     <= gap;
            end
          end
          state <= ST_FETCH;
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (has_result) begin
              m_tvalid       <= 1'b1;
              m_tuser        <= res_kind;
              m_tdata        <= {res_total, res_gap, res_byte};
              m_tlast        <= !more;
              read_position  <= read_position_next;
              line_feed_owed <= line_feed_owed_next;
              if (clear_notice) begin
                notice_pending <= 1'b0;
                notice_gap     <= '0;
              end
              room  <= room_left;
              state <= more ? ST_FETCH : ST_IDLE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A notice is always sent within the drain that raised it
  a_no_notice_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !notice_pending)
    else $error("notice left pending after drain");

  // An owed LF and a pending notice never coexist
  a_notice_lf: assert property (@(posedge clk) disable iff (rst)
    notice_pending |-> !line_feed_owed)
    else $error("owed LF alongside pending notice");

  // Emitting with no room left would overrun the transmitter
  a_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (room != '0))
    else $error("emit with empty burst budget");

  // A notice result carries no byte
  a_notice_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_NOTICE)) |-> (m_tdata[BYTE_W-1:0] == '0))
    else $error("notice result with byte data");

  // A burst ends on a last result before a new item is taken
  a_last_before_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && out_free && has_result && !more) |=>
      (m_tvalid && m_tlast))
    else $error("burst end not marked last");
`endif

endmodule

[design/log_ring_to_uart_drainer.sv]
// ----------------------------------------------------------------------------
// log_ring_to_uart_drainer: overwriting log ring drained toward a UART FIFO
// Log bytes are appended to a ring; each drain item sends a lost-bytes notice
// (if the reader was overrun) and then ring bytes with LF sent as CR LF.
// ----------------------------------------------------------------------------
// Timing: the input side takes one item per cycle while the queue has room,
// into a four-entry command queue. The back part executes an append as it pops
// it. A drain runs the overrun check (ST_CHECK, ST_APPLY), then for each result
// a ring memory read (ST_FETCH) and an emit (ST_EMIT), plus any wait on
// m_tready. A drain with nothing to send goes back to idle from ST_EMIT. The ring
// memory has one write and one registered read port and needs no clearing after
// reset. RING_DEPTH must be a power of two. fifo_depth may only be written while
// the block is idle; 0 acts as 1 and values above MAX_BURST act as MAX_BURST.
// ----------------------------------------------------------------------------
module log_ring_to_uart_drainer import lrud_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,   // fifo_depth
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,    // [7:0] log_byte
  input  logic              s_tuser,    // [0] command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,    // [7:0] out_byte, [39:8] gap_bytes,
                                        // [71:40] total_lost
  output logic              m_tuser,    // [0] kind
  output logic              m_tlast     // last
);

  cmd_head_t head;
  logic      pop;

  // Input acceptance and command queue
  lrud_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  // Ring storage and drain sequencer
  lrud_back #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
